@@ src/tmk_pkg.sv @@
// Shared types, constants and helpers for the thin multipole kick block.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none
package tmk_pkg;

  localparam int CWID    = 32;  // coordinate / coefficient width
  localparam int AW      = 52;  // accumulator width
  localparam int MW      = 33;  // multiplier operand width
  localparam int PW      = 66;  // multiplier product width
  localparam int DW      = 48;  // divider dividend width
  localparam int DSTEP   = 8;   // quotient bits per divider cycle
  localparam int DCYC    = DW / DSTEP;
  localparam int DCW     = 3;   // divider cycle counter width
  localparam int CFG_IW  = 3;   // config index width
  localparam int NCW     = 4;   // num_components width
  localparam int OFW     = 4;   // order field width
  localparam int SLW     = 3;   // slot field width
  localparam int AXW     = 26;  // capped scaled aperture width
  localparam int SQW     = 52;  // sum of squares width

  localparam logic signed [AW-1:0] SAT_HI = {{(AW-CWID+1){1'b0}}, {(CWID-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-CWID+1){1'b1}}, {(CWID-1){1'b0}}};
  localparam logic signed [AW-1:0] ONE_Q24 = AW'(64'sd16777216);
  localparam logic signed [CWID-1:0] ONE_Q24_C = 32'sd16777216;
  localparam logic [AXW-1:0] AX_CAP = 26'h2000000;
  localparam logic [SQW:0] SQ_LIMIT = 53'h1000000000000;
  localparam logic [CWID-1:0] RIGID_RST = 32'h00010000;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BEND  = 3'd0,
    CFG_CURV  = 3'd1,
    CFG_RIGID = 3'd2,
    CFG_APX   = 3'd3,
    CFG_APY   = 3'd4,
    CFG_NCOMP = 3'd5
  } cfg_idx_e;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRACK = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [SLW-1:0]         slot;
    logic [OFW-1:0]         order;
    logic signed [CWID-1:0] an_coef;
    logic signed [CWID-1:0] bn_coef;
    logic signed [CWID-1:0] x_in;
    logic signed [CWID-1:0] px_in;
    logic signed [CWID-1:0] y_in;
    logic signed [CWID-1:0] py_in;
    logic signed [CWID-1:0] ct_in;
    logic signed [CWID-1:0] dp_in;
    logic                   alive_in;
  } tmk_in_t;

  typedef struct packed {
    logic signed [CWID-1:0] x_out;
    logic signed [CWID-1:0] px_out;
    logic signed [CWID-1:0] y_out;
    logic signed [CWID-1:0] py_out;
    logic signed [CWID-1:0] ct_out;
    logic signed [CWID-1:0] dp_out;
    logic                   alive_out;
  } tmk_out_t;

  // clamp an accumulator value into the signed coordinate range
  function automatic logic signed [CWID-1:0] sat_c(input logic signed [AW-1:0] v);
    logic signed [CWID-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CWID-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CWID-1:0];
    end else begin
      r = v[CWID-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [AW-1:0] ext_c(input logic signed [CWID-1:0] v);
    return AW'(v);
  endfunction

endpackage
`default_nettype wire

@@ src/tmk_if.sv @@
// Valid/ready channel interfaces for the thin multipole kick block.
// Depends on tmk_pkg for the payload types and config widths.
`default_nettype none
interface tmk_in_if;
  logic             valid;
  logic             ready;
  tmk_pkg::tmk_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tmk_out_if;
  logic              valid;
  logic              ready;
  tmk_pkg::tmk_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tmk_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tmk_pkg::CFG_IW-1:0]    index;
  logic [tmk_pkg::CWID-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/thin_multipole_kick.sv @@
// Thin multipole kick: top level with sequencer, shared multiplier and divider.
// Depends on tmk_pkg and the channel interfaces in tmk_if.sv.
//
// Usage:
//  - in_i carries load items (opcode 0: write one component table slot) and
//    track items (opcode 1: kick one particle). out_o returns one result per
//    track item; loads give none. cfg_i writes registers 0..5, always ready,
//    and is meant to be written while the block is idle.
//  - A load transfer leaves the sequencer idle. A lost particle (alive_in 0)
//    goes straight to the done state and is passed through unchanged. A
//    living particle runs the power, divide, write, component and final
//    steps: every power z^k/k! costs four products on the shared 33x33
//    multiplier plus a divide-by-k (8 quotient bits a cycle), each component
//    four more products, the final kick and aperture nine.
//  - in_i.ready is high only while the sequencer idles; one item is in
//    work at a time.
//  - The finished result moves into an output register; if the receiver
//    stalls, that register holds and the next item can already be taken
//    and computed, waiting only at its own end for the register to free.
//  - Reset clears control state and sets registers to their defaults; the
//    component table is not cleared and must be loaded before use.
`default_nettype none
module thin_multipole_kick #(
  parameter int MAX_COMPONENTS = 8,
  parameter int MAX_ORDER      = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmk_in_if.sink    in_i,
  tmk_out_if.source out_o,
  tmk_cfg_if.sink   cfg_i
);
  import tmk_pkg::*;

  localparam int IW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CW = $clog2(MAX_COMPONENTS + 1);
  localparam int OW = $clog2(MAX_ORDER + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POW  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_WST  = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  // sequencer
  state_e          state_q, state_d;
  logic [3:0]      sub_q, sub_d;
  logic [OW-1:0]   k_q, k_d;
  logic [CW-1:0]   comp_q, comp_d;
  logic [DCW-1:0]  dcnt_q, dcnt_d;

  // configuration
  logic signed [CWID-1:0] bend_q, bend_d, curv_q, curv_d;
  logic [CWID-1:0]        rigid_q, rigid_d, apx_q, apx_d, apy_q, apy_d;
  logic [NCW-1:0]         ncomp_q, ncomp_d;

  // particle
  logic signed [CWID-1:0] x_q, x_d, px_q, px_d, y_q, y_d;
  logic signed [CWID-1:0] py_q, py_d, ct_q, ct_d, dp_q, dp_d;
  logic                   alive_q, alive_d;

  // component table, powers table
  logic [OW-1:0]          ord_q [MAX_COMPONENTS];
  logic signed [CWID-1:0] an_q  [MAX_COMPONENTS];
  logic signed [CWID-1:0] bn_q  [MAX_COMPONENTS];
  logic signed [CWID-1:0] wr_q  [MAX_ORDER+1];
  logic signed [CWID-1:0] wi_q  [MAX_ORDER+1];
  logic                   ld_we, w_we;
  logic [IW-1:0]          ld_idx;
  logic [OW-1:0]          ld_ord, w_idx;
  logic signed [CWID-1:0] w_re, w_im;

  // datapath
  logic signed [CWID-1:0] wcr_q, wcr_d, wci_q, wci_d;
  logic signed [AW-1:0]   acc_r_q, acc_r_d, acc_i_q, acc_i_d;
  logic [DW-1:0]          dr_q, dr_d, di_q, di_d;
  logic [OW-1:0]          rr_q, rr_d, ri_q, ri_d;
  logic                   nr_q, nr_d, ni_q, ni_d;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [CWID-1:0] inner_q, inner_d, t1_q, t1_d;
  logic [AXW-1:0]         ax_q, ax_d, ay_q, ay_d;
  logic [SQW-1:0]         sq_q, sq_d;

  // output register
  tmk_out_t out_q, out_d;
  logic     ov_q, ov_d;

  logic signed [AW-1:0] p24, p16;
  logic [PW-17:0]       pa;
  logic [AXW-1:0]       pcap;
  logic [SQW:0]         sqsum;
  logic [CWID-1:0]      absx, absy;
  logic [IW-1:0]        cidx;
  logic [OW-1:0]        cord;
  logic [CW-1:0]        ncomp_eff;
  logic [OW+DW-1:0]     stp_r, stp_i;
  logic signed [AW-1:0] q_r, q_i;
  logic                 in_fire;

  function automatic logic [OW+DW-1:0] div_step(input logic [OW-1:0] r,
                                                input logic [DW-1:0] d,
                                                input logic [OW-1:0] k);
    logic [OW:0]    t;
    logic [OW-1:0]  rr;
    logic [DW-1:0]  dd;
    rr = r;
    dd = d;
    for (int i = 0; i < DSTEP; i++) begin
      t  = {rr, dd[DW-1]};
      dd = {dd[DW-2:0], 1'b0};
      if (t >= {1'b0, k}) begin
        t     = t - {1'b0, k};
        dd[0] = 1'b1;
      end
      rr = t[OW-1:0];
    end
    return {rr, dd};
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] a;
    a = v[AW-1] ? -v : v;
    return a[DW-1:0];
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;
  assign in_fire     = in_i.valid && (state_q == S_IDLE);

  assign p24   = AW'(prod_q >>> 24);
  assign p16   = AW'(prod_q >>> 16);
  assign pa    = prod_q[PW-1:16];
  assign pcap  = (pa > (PW-16)'(AX_CAP)) ? AX_CAP : pa[AXW-1:0];
  assign sqsum = (SQW+1)'(sq_q) + (SQW+1)'(prod_q[SQW-1:0]);
  assign absx  = x_q[CWID-1] ? (~x_q + 1'b1) : x_q;
  assign absy  = y_q[CWID-1] ? (~y_q + 1'b1) : y_q;
  assign cidx  = comp_q[IW-1:0];
  assign cord  = ord_q[cidx];
  assign ncomp_eff = (int'(ncomp_q) > MAX_COMPONENTS) ? CW'(MAX_COMPONENTS) : CW'(ncomp_q);
  assign stp_r = div_step(rr_q, dr_q, k_q);
  assign stp_i = div_step(ri_q, di_q, k_q);
  assign q_r   = nr_q ? -AW'($signed({1'b0, dr_q})) : AW'($signed({1'b0, dr_q}));
  assign q_i   = ni_q ? -AW'($signed({1'b0, di_q})) : AW'($signed({1'b0, di_q}));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_POW: begin
        unique case (sub_q)
          4'd0:    begin mul_a = MW'(wcr_q); mul_b = MW'(x_q); end
          4'd1:    begin mul_a = MW'(wci_q); mul_b = MW'(y_q); end
          4'd2:    begin mul_a = MW'(wcr_q); mul_b = MW'(y_q); end
          4'd3:    begin mul_a = MW'(wci_q); mul_b = MW'(x_q); end
          default: ;
        endcase
      end
      S_CMP: begin
        unique case (sub_q)
          4'd0:    begin mul_a = MW'(bn_q[cidx]); mul_b = MW'(wr_q[cord]); end
          4'd1:    begin mul_a = MW'(an_q[cidx]); mul_b = MW'(wi_q[cord]); end
          4'd2:    begin mul_a = MW'(bn_q[cidx]); mul_b = MW'(wi_q[cord]); end
          4'd3:    begin mul_a = MW'(an_q[cidx]); mul_b = MW'(wr_q[cord]); end
          default: ;
        endcase
      end
      S_FIN: begin
        unique case (sub_q)
          4'd0: begin mul_a = MW'(curv_q); mul_b = MW'(x_q); end
          4'd1: begin mul_a = MW'(bend_q); mul_b = MW'(x_q); end
          4'd2: begin
            mul_a = MW'($signed(acc_r_q[CWID-1:0]));
            mul_b = $signed({1'b0, rigid_q});
          end
          4'd3: begin
            mul_a = MW'($signed(acc_i_q[CWID-1:0]));
            mul_b = $signed({1'b0, rigid_q});
          end
          4'd4: begin mul_a = $signed({1'b0, absx}); mul_b = $signed({1'b0, apx_q}); end
          4'd5: begin mul_a = $signed({1'b0, absy}); mul_b = $signed({1'b0, apy_q}); end
          4'd6: begin mul_a = MW'(bend_q); mul_b = MW'(inner_q); end
          4'd7: begin
            mul_a = $signed({(MW-AXW)'(0), ax_q});
            mul_b = $signed({(MW-AXW)'(0), ax_q});
          end
          4'd8: begin
            mul_a = $signed({(MW-AXW)'(0), ay_q});
            mul_b = $signed({(MW-AXW)'(0), ay_q});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // sequencer and datapath next state
  always_comb begin
    state_d = state_q;  sub_d = sub_q;  k_d = k_q;  comp_d = comp_q;  dcnt_d = dcnt_q;
    bend_d = bend_q;  curv_d = curv_q;  rigid_d = rigid_q;
    apx_d = apx_q;  apy_d = apy_q;  ncomp_d = ncomp_q;
    x_d = x_q;  px_d = px_q;  y_d = y_q;  py_d = py_q;  ct_d = ct_q;  dp_d = dp_q;
    alive_d = alive_q;
    wcr_d = wcr_q;  wci_d = wci_q;  acc_r_d = acc_r_q;  acc_i_d = acc_i_q;
    dr_d = dr_q;  di_d = di_q;  rr_d = rr_q;  ri_d = ri_q;  nr_d = nr_q;  ni_d = ni_q;
    inner_d = inner_q;  t1_d = t1_q;  ax_d = ax_q;  ay_d = ay_q;  sq_d = sq_q;
    out_d = out_q;
    ov_d  = ov_q && !out_o.ready;
    ld_we = 1'b0;
    ld_idx = IW'(in_i.data.slot);
    ld_ord = (int'(in_i.data.order) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(in_i.data.order);
    w_we = 1'b0;  w_idx = k_q;
    w_re = sat_c(q_r);  w_im = sat_c(q_i);

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BEND:  bend_d  = $signed(cfg_i.data);
        CFG_CURV:  curv_d  = $signed(cfg_i.data);
        CFG_RIGID: rigid_d = cfg_i.data;
        CFG_APX:   apx_d   = cfg_i.data;
        CFG_APY:   apy_d   = cfg_i.data;
        CFG_NCOMP: ncomp_d = cfg_i.data[NCW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.data.opcode == OP_LOAD) begin
            ld_we = (int'(in_i.data.slot) < MAX_COMPONENTS);
          end else begin
            x_d  = in_i.data.x_in;   px_d = in_i.data.px_in;
            y_d  = in_i.data.y_in;   py_d = in_i.data.py_in;
            ct_d = in_i.data.ct_in;  dp_d = in_i.data.dp_in;
            alive_d = in_i.data.alive_in;
            if (in_i.data.alive_in) begin
              // seed z^0/0! = 1
              w_we = 1'b1;  w_idx = '0;
              w_re = ONE_Q24_C;  w_im = '0;
              wcr_d = ONE_Q24_C;  wci_d = '0;
              acc_r_d = '0;  acc_i_d = '0;
              k_d = OW'(1);  sub_d = '0;
              state_d = S_POW;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_POW: begin
        sub_d = sub_q + 4'd1;
        unique case (sub_q)
          4'd1:    acc_r_d = acc_r_q + p24;
          4'd2:    acc_r_d = acc_r_q - p24;
          4'd3:    acc_i_d = acc_i_q + p24;
          4'd4:    acc_i_d = acc_i_q + p24;
          default: ;
        endcase
        if (sub_q == 4'd4) begin
          dcnt_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == '0) begin
          dr_d = mag(acc_r_q);  di_d = mag(acc_i_q);
          nr_d = acc_r_q[AW-1];  ni_d = acc_i_q[AW-1];
          rr_d = '0;  ri_d = '0;
        end else begin
          {rr_d, dr_d} = stp_r;
          {ri_d, di_d} = stp_i;
          if (dcnt_q == DCW'(DCYC)) begin
            state_d = S_WST;
          end
        end
      end
      S_WST: begin
        w_we = 1'b1;
        wcr_d = w_re;  wci_d = w_im;
        acc_r_d = '0;  acc_i_d = '0;
        sub_d = '0;
        if (k_q == OW'(MAX_ORDER)) begin
          comp_d  = '0;
          state_d = (ncomp_eff == '0) ? S_FIN : S_CMP;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_POW;
        end
      end
      S_CMP: begin
        sub_d = sub_q + 4'd1;
        unique case (sub_q)
          4'd1:    acc_r_d = acc_r_q + p16;
          4'd2:    acc_r_d = acc_r_q - p16;
          4'd3:    acc_i_d = acc_i_q + p16;
          default: ;
        endcase
        if (sub_q == 4'd4) begin
          // partial sums saturate after each component
          acc_r_d = ext_c(sat_c(acc_r_q));
          acc_i_d = ext_c(sat_c(acc_i_q + p16));
          comp_d  = comp_q + 1'b1;
          sub_d   = '0;
          if (comp_q + 1'b1 == ncomp_eff) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        sub_d = sub_q + 4'd1;
        unique case (sub_q)
          4'd1:  inner_d = sat_c(ONE_Q24 + ext_c(dp_q) - p24);
          4'd2:  ct_d    = sat_c(ext_c(ct_q) - ext_c(sat_c(p24)));
          4'd3:  t1_d    = sat_c(p16);
          4'd4:  py_d    = sat_c(ext_c(py_q) + ext_c(sat_c(p16)));
          4'd5:  ax_d    = pcap;
          4'd6:  ay_d    = pcap;
          4'd7:  px_d    = sat_c(ext_c(px_q) + ext_c(sat_c(p24)) - ext_c(t1_q));
          4'd8:  sq_d    = prod_q[SQW-1:0];
          4'd9: begin
            if ((apx_q != '0) && (apy_q != '0) && (sqsum > SQ_LIMIT)) begin
              alive_d = 1'b0;
            end
            state_d = S_DONE;
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          out_d = '{x_out: x_q, px_out: px_q, y_out: y_q, py_out: py_q,
                    ct_out: ct_q, dp_out: dp_q, alive_out: alive_q};
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sub_q   <= '0;
      k_q     <= '0;
      comp_q  <= '0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
      bend_q  <= '0;
      curv_q  <= '0;
      rigid_q <= RIGID_RST;
      apx_q   <= '0;
      apy_q   <= '0;
      ncomp_q <= '0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      k_q     <= k_d;
      comp_q  <= comp_d;
      dcnt_q  <= dcnt_d;
      ov_q    <= ov_d;
      bend_q  <= bend_d;
      curv_q  <= curv_d;
      rigid_q <= rigid_d;
      apx_q   <= apx_d;
      apy_q   <= apy_d;
      ncomp_q <= ncomp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;  px_q <= px_d;  y_q <= y_d;  py_q <= py_d;  ct_q <= ct_d;  dp_q <= dp_d;
    alive_q <= alive_d;
    wcr_q <= wcr_d;  wci_q <= wci_d;
    acc_r_q <= acc_r_d;  acc_i_q <= acc_i_d;
    dr_q <= dr_d;  di_q <= di_d;  rr_q <= rr_d;  ri_q <= ri_d;  nr_q <= nr_d;  ni_q <= ni_d;
    prod_q <= prod_d;
    inner_q <= inner_d;  t1_q <= t1_d;  ax_q <= ax_d;  ay_q <= ay_d;  sq_q <= sq_d;
    out_q <= out_d;
    if (ld_we) begin
      ord_q[ld_idx] <= ld_ord;
      an_q[ld_idx]  <= in_i.data.an_coef;
      bn_q[ld_idx]  <= in_i.data.bn_coef;
    end
    if (w_we) begin
      wr_q[w_idx] <= w_re;
      wi_q[w_idx] <= w_im;
    end
  end

endmodule
`default_nettype wire

@@ src/tmk_checker.sv @@
// Port-level checks for thin_multipole_kick, attached by bind.
// Depends on tmk_pkg for the opcode constants.
`default_nettype none
module tmk_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_opcode_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  import tmk_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // a pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a track transfer occupies the block
  a_track_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_opcode_i == OP_TRACK) |=> !in_ready_i)
    else $error("ready after track transfer");

  // a load transfer leaves the block ready again in the next cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_opcode_i == OP_LOAD) |=> in_ready_i)
    else $error("load did not return to idle");

  // a new result only appears from a busy block
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result without work");

endmodule

bind thin_multipole_kick tmk_checker u_tmk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.data.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
`default_nettype wire

@@ tb/tmk_checker.sv @@
// Checker for the thin multipole kick: watches the load/track, result and
// register channels, predicts each result and compares it. Uses tmk_pkg.
module tmk_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmk_in_if           in_m,
  tmk_out_if          out_m,
  tmk_cfg_if          cfg_m,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import tmk_pkg::*;

  localparam int NSLOT = 8;
  localparam int TOP_ORDER = 15;

  longint bend_q, curv_q, rigid_q, apx_q, apy_q, ncomp_q;
  longint comp_an[NSLOT], comp_bn[NSLOT];
  int     comp_ord[NSLOT];
  tmk_out_t kicked_q[$];

  assign pending_o = kicked_q.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // kick one particle with the current table and registers
  function automatic tmk_out_t kick_particle(tmk_in_t it);
    tmk_out_t r;
    longint x, px, y, py, ct, dp, nr, ni, byl, bxl, inner, bend, t, ax, ay, nc, an, bn;
    longint wr[TOP_ORDER+1], wi[TOP_ORDER+1];
    logic alive;
    int n;
    x = it.x_in; px = it.px_in; y = it.y_in; py = it.py_in;
    ct = it.ct_in; dp = it.dp_in; alive = it.alive_in;
    if (alive) begin
      wr[0] = 64'sd16777216;
      wi[0] = 0;
      for (int k = 1; k <= TOP_ORDER; k++) begin
        nr = ((wr[k-1] * x) >>> 24) - ((wi[k-1] * y) >>> 24);
        ni = ((wr[k-1] * y) >>> 24) + ((wi[k-1] * x) >>> 24);
        wr[k] = clamp32(nr / k);   // truncates toward zero
        wi[k] = clamp32(ni / k);
      end
      byl = 0;
      bxl = 0;
      nc = (ncomp_q > NSLOT) ? NSLOT : ncomp_q;
      for (int k = 0; k < nc; k++) begin
        n = comp_ord[k];
        an = comp_an[k];
        bn = comp_bn[k];
        byl = clamp32(byl + ((bn * wr[n]) >>> 16) - ((an * wi[n]) >>> 16));
        bxl = clamp32(bxl + ((bn * wi[n]) >>> 16) + ((an * wr[n]) >>> 16));
      end
      inner = clamp32(64'sd16777216 + dp - ((curv_q * x) >>> 24));
      bend = clamp32((bend_q * inner) >>> 24);
      t = clamp32((byl * rigid_q) >>> 16);
      px = clamp32(px + bend - t);
      t = clamp32((bxl * rigid_q) >>> 16);
      py = clamp32(py + t);
      t = clamp32((bend_q * x) >>> 24);
      ct = clamp32(ct - t);
      if (apx_q != 0 && apy_q != 0) begin
        ax = ((x < 0 ? -x : x) * apx_q) >>> 16;
        ay = ((y < 0 ? -y : y) * apy_q) >>> 16;
        if (ax > (64'sd1 << 25)) ax = 64'sd1 << 25;
        if (ay > (64'sd1 << 25)) ay = 64'sd1 << 25;
        if (ax * ax + ay * ay > (64'sd1 << 48)) alive = 1'b0;
      end
    end
    r.x_out = x[31:0]; r.px_out = px[31:0]; r.y_out = y[31:0];
    r.py_out = py[31:0]; r.ct_out = ct[31:0]; r.dp_out = dp[31:0];
    r.alive_out = alive;
    return r;
  endfunction

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tmk_out_t e, a;
    if (!rst_ni) begin
      bend_q = 0; curv_q = 0; rigid_q = 65536; apx_q = 0; apy_q = 0; ncomp_q = 0;
      for (int i = 0; i < NSLOT; i++) begin
        comp_ord[i] = 0; comp_an[i] = 0; comp_bn[i] = 0;
      end
      kicked_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.index)
          CFG_BEND:  bend_q = longint'($signed(cfg_m.data));
          CFG_CURV:  curv_q = longint'($signed(cfg_m.data));
          CFG_RIGID: rigid_q = longint'(cfg_m.data);
          CFG_APX:   apx_q = longint'(cfg_m.data);
          CFG_APY:   apy_q = longint'(cfg_m.data);
          CFG_NCOMP: ncomp_q = longint'(cfg_m.data[3:0]);
          default: ;
        endcase
      end
      if (out_m.valid && out_m.ready) begin
        a = out_m.data;
        if (kicked_q.size() == 0) begin
          $error("result transfer with no particle outstanding");
          fail_count_o++;
        end else begin
          e = kicked_q.pop_front();
          cmp_field("x_out", e.x_out, a.x_out);
          cmp_field("px_out", e.px_out, a.px_out);
          cmp_field("y_out", e.y_out, a.y_out);
          cmp_field("py_out", e.py_out, a.py_out);
          cmp_field("ct_out", e.ct_out, a.ct_out);
          cmp_field("dp_out", e.dp_out, a.dp_out);
          cmp_field("alive_out", 32'(e.alive_out), 32'(a.alive_out));
        end
      end
      if (in_m.valid && in_m.ready) begin
        if (in_m.data.opcode == OP_TRACK) begin
          kicked_q.push_back(kick_particle(in_m.data));
        end else begin
          comp_ord[in_m.data.slot] = in_m.data.order;
          comp_an[in_m.data.slot] = longint'(in_m.data.an_coef);
          comp_bn[in_m.data.slot] = longint'(in_m.data.bn_coef);
        end
      end
    end
  end
endmodule

@@ tb/tb.sv @@
// Top of the thin multipole kick testbench: clock, reset, stimulus and verdict.
// Depends on tmk_pkg, tmk_if.sv, the block and tmk_checker.
module tb;
  import tmk_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd6;  // no register behind this index
  localparam int HOLD_CYCLES = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending;
  int max_gap;       // per-phase ceiling of sender and receiver waits
  bit hold_req;      // asks the receiver for one long hold-off

  tmk_in_if  in_ch();
  tmk_out_if out_ch();
  tmk_cfg_if cfg_ch();

  thin_multipole_kick dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  tmk_tb_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_m        (in_ch),
    .out_m       (out_ch),
    .cfg_m       (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Generous cap: it leaves several times the slowest legal run including
  // gaps and the long hold.
  initial begin
    #30000000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------- item builders ----------
  function automatic tmk_in_t load_item(logic [2:0] slot, logic [3:0] ord,
                                        logic [31:0] an, logic [31:0] bn);
    tmk_in_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.slot = slot;
    it.order = ord;
    it.an_coef = an;
    it.bn_coef = bn;
    // coordinates are don't-care for a load; randomize so their bits toggle
    it.x_in = $urandom; it.px_in = $urandom; it.y_in = $urandom;
    it.py_in = $urandom; it.ct_in = $urandom; it.dp_in = $urandom;
    it.alive_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic tmk_in_t track_item(logic [31:0] x, logic [31:0] px, logic [31:0] y,
                                         logic [31:0] py, logic [31:0] ct, logic [31:0] dp,
                                         logic alive);
    tmk_in_t it;
    it.opcode = OP_TRACK;
    it.slot = 3'($urandom);
    it.order = 4'($urandom);
    it.an_coef = $urandom;
    it.bn_coef = $urandom;
    it.x_in = x; it.px_in = px; it.y_in = y; it.py_in = py;
    it.ct_in = ct; it.dp_in = dp; it.alive_in = alive;
    return it;
  endfunction

  // Coordinates: half within a few units so z^n/n! stays meaningful, the other
  // half full range or at the extremes to drive the saturation paths.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      3:       return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      4:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  // ---------- channel drivers ----------
  // Ready is looked at on the falling edge, so the transfer decision never
  // races the rising edge updates of the block.
  task automatic send_item(tmk_in_t it);
    int gap;
    bit ok;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    forever begin
      @(negedge clk_i);
      ok = in_ch.ready;
      @(posedge clk_i);
      if (ok) break;
    end
  endtask

  // Dropping valid between writes keeps valid from being driven twice
  // in one time step by back to back writes.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
    bit ok;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    forever begin
      @(negedge clk_i);
      ok = cfg_ch.ready;
      @(posedge clk_i);
      if (ok) break;
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain: every particle back, then a wait for a trailing load transfer.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] bend, logic [31:0] curv, logic [31:0] rigid,
                          logic [31:0] apx, logic [31:0] apy, logic [31:0] ncomp);
    write_reg(CFG_BEND, bend);
    write_reg(CFG_CURV, curv);
    write_reg(CFG_RIGID, rigid);
    write_reg(CFG_APX, apx);
    write_reg(CFG_APY, apy);
    write_reg(CFG_NCOMP, ncomp);
  endtask

  // Random traffic: mostly living particles, some table reloads, some lost ones.
  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: send_item(load_item(3'($urandom), 4'($urandom), rand_coef(), rand_coef()));
        2:    send_item(track_item(rand_coord(), $urandom, rand_coord(), $urandom,
                                   $urandom, $urandom, 1'b0));
        default:
          send_item(track_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), 1'b1));
      endcase
    end
  endtask

  // ---------- receiver ----------
  initial begin
    int n;
    bit ok;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        // long hold-off: output register fills, the block stops taking input
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      n = $urandom_range(0, max_gap);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      forever begin
        @(negedge clk_i);
        ok = out_ch.valid;
        @(posedge clk_i);
        if (ok) break;
      end
    end
  end

  // ---------- stimulus and verdict ----------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BEND;
    cfg_ch.data = '0;
    max_gap = 8;
    hold_req = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every slot before any living particle can read the table.
    send_item(load_item(3'd0, 4'd0, 32'h0001_0000, 32'h0002_0000));
    send_item(load_item(3'd1, 4'd15, 32'h7fff_ffff, 32'h8000_0000));
    send_item(load_item(3'd2, 4'd1, 32'h8000_0000, 32'h7fff_ffff));
    send_item(load_item(3'd3, 4'd7, 32'hffff_0000, 32'h0000_8000));
    send_item(load_item(3'd4, 4'd3, 32'h0000_0000, 32'h0003_0000));
    send_item(load_item(3'd5, 4'd2, 32'h0001_8000, 32'hfffe_0000));
    send_item(load_item(3'd6, 4'd14, 32'h0000_0001, 32'hffff_ffff));
    send_item(load_item(3'd7, 4'd5, 32'h0010_0000, 32'h0000_4000));

    // Directed: default registers first (no components in use).
    send_item(track_item(32'h0100_0000, 32'h0, 32'h0080_0000, 32'h0, 32'h0, 32'h0, 1'b1));
    settle();
    // Orders out of sequence, count beyond the table, unknown register index.
    set_regs(32'h0000_4000, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd15);
    write_reg(CFG_UNUSED, 32'hffff_ffff);
    send_item(track_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    send_item(track_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
    send_item(track_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 1'b1));
    // lost particle passes straight through
    send_item(track_item(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
                         32'h5555_5555, 32'haaaa_aaaa, 1'b0));
    // aperture: just inside, on the boundary, and outside the unit ellipse
    send_item(track_item(32'h00ff_ffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    send_item(track_item(32'h00b5_0000, 32'h0, 32'h00b5_0000, 32'h0, 32'h0, 32'h0, 1'b1));
    send_item(track_item(32'h0100_0001, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 1'b1));
    send_item(track_item(32'hff00_0000, 32'h0, 32'hff40_0000, 32'h0, 32'h0, 32'h0, 1'b1));
    settle();

    // Random phases, each under its own register setting.
    set_regs(32'h0000_1000, 32'hffff_0000, 32'h0000_8000, 32'h0, 32'h0002_0000, 32'd8);
    random_phase(180);
    settle();

    // Block fills up against a stalled receiver; no idling on the sender.
    max_gap = 0;
    set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'd8);
    hold_req = 1'b1;
    random_phase(180);
    settle();

    max_gap = 8;
    set_regs(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0000_8000, 32'd0);
    random_phase(150);
    settle();

    set_regs($urandom, $urandom, $urandom, $urandom_range(1, 32'h0004_0000),
             $urandom_range(1, 32'h0004_0000), $urandom_range(1, 8));
    random_phase(200);
    settle();

    max_gap = 3;
    set_regs(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'h0000_4000,
             32'd4);
    random_phase(200);
    settle();

    max_gap = 8;
    set_regs($urandom, $urandom, $urandom, $urandom, $urandom, 32'd8);
    random_phase(270);
    settle();

    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ files.f @@
src/tmk_pkg.sv
src/tmk_if.sv
src/thin_multipole_kick.sv
src/tmk_checker.sv
tb/tmk_checker.sv
tb/tb.sv
